// ===== sv/h2c_pkg.sv =====
package h2c_pkg;

  localparam int MAX_DIM      = 16;
  localparam int CORDIC_STEPS = 16;

  // Effective dimension never exceeds the 4-bit component index range.
  localparam int DIM_CAP = (MAX_DIM < 16) ? MAX_DIM : 16;
  localparam int STEP_W  = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

  // Datapath widths: x and y stay below 2^47 in magnitude, z below 2^31.
  localparam int XY_W = 50;
  localparam int Z_W  = 34;

  // CORDIC gain compensation in Q31.
  localparam logic [31:0] GAIN_Q31 = 32'h4DBA76D4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_PREP,
    ST_ROT,
    ST_EMIT0,
    ST_EMIT1
  } h2c_state_t;

  // round(atan(2^-i) * 2^32 / (2*pi))
  function automatic logic [31:0] atan_entry(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      5'd24: v = 32'd41;
      5'd25: v = 32'd20;
      5'd26: v = 32'd10;
      5'd27: v = 32'd5;
      5'd28: v = 32'd3;
      5'd29: v = 32'd1;
      5'd30: v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== sv/hyperspherical_to_cartesian.sv =====
// Hyperspherical to Cartesian converter. Each input transfer carries one angle
// (and, on the first angle of a vector, the Q16.16 radius); a vector of
// dimension N takes N-1 transfers and yields N component results, counting
// down from index N-1, with the last angle producing index 0 and then index 1
// (flagged by vector_done). A negative radius sets bad_radius and zeroes every
// component of that vector. Each item passes in order through taking the
// transfer, the gain multiply, quadrant folding, one iteration per step of the
// single shared CORDIC rotation stage, and one emit per result, which waits
// while the output register is full and stalled. The input is stalled while an
// item is in work; a finished result waits in the output register while the
// next item is taken. Writing the dimension register abandons any partial
// vector.
module hyperspherical_to_cartesian import h2c_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [4:0]         cfg_wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_radius,
  input  logic signed [31:0] in_angle,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_component,
  output logic [3:0]         out_component_index,
  output logic               out_vector_done,
  output logic               out_bad_radius
);

  h2c_state_t state_r, state_nxt;

  logic [4:0]              dim_r, dim_nxt;
  logic [3:0]              pos_r, pos_nxt;
  logic                    err_r, err_nxt;
  logic [31:0]             rp_r, rp_nxt;
  logic [31:0]             p_r, p_nxt;
  logic [31:0]             ang_r, ang_nxt;
  logic signed [62:0]      prod_r, prod_nxt;
  logic signed [XY_W-1:0]  x_r, x_nxt;
  logic signed [XY_W-1:0]  y_r, y_nxt;
  logic signed [Z_W-1:0]   z_r, z_nxt;
  logic [STEP_W-1:0]       step_r, step_nxt;

  logic                    ov_r, ov_nxt;
  logic [31:0]             oc_r, oc_nxt;
  logic [3:0]              oi_r, oi_nxt;
  logic                    od_r, od_nxt;
  logic                    ob_r, ob_nxt;

  logic [4:0]              dim_eff;
  logic                    last_angle;
  logic [4:0]              idx_full;
  logic                    out_free;
  logic signed [62:0]      prod_full;
  logic signed [XY_W-1:0]  x_scaled;
  logic                    fold;
  logic signed [XY_W-1:0]  dx, dy;
  logic signed [Z_W-1:0]   atan_z;
  logic [31:0]             cos_q, sin_q;

  // Round to Q16.16 and saturate to the signed 32-bit range.
  function automatic logic [31:0] to_q16(input logic signed [XY_W-1:0] v);
    logic signed [XY_W:0]    sum;
    logic signed [XY_W-16:0] t;
    logic [31:0]             r;
    sum = $signed({v[XY_W-1], v}) + $signed((XY_W+1)'(32768));
    t   = sum[XY_W:16];
    if (t > $signed((XY_W-15)'(32'h7FFFFFFF))) begin
      r = 32'h7FFFFFFF;
    end else if (t < -$signed((XY_W-15)'(33'h080000000))) begin
      r = 32'h80000000;
    end else begin
      r = t[31:0];
    end
    return r;
  endfunction

  always_comb begin
    if (dim_r < 5'd2) begin
      dim_eff = 5'd2;
    end else if (dim_r > 5'(DIM_CAP)) begin
      dim_eff = 5'(DIM_CAP);
    end else begin
      dim_eff = dim_r;
    end
  end

  assign last_angle = ({1'b0, pos_r} + 5'd1) >= (dim_eff - 5'd1);
  assign idx_full   = dim_eff - 5'd1 - {1'b0, pos_r};
  assign out_free   = !ov_r || !out_stall;

  assign prod_full = $signed(p_r) * $signed({1'b0, GAIN_Q31});
  // Arithmetic shift right by 15 leaves 32 fractional bits.
  assign x_scaled  = {{(XY_W-48){prod_r[62]}}, prod_r[62:15]};
  assign fold      = ang_r[31] ^ ang_r[30];

  assign dx     = y_r >>> step_r;
  assign dy     = x_r >>> step_r;
  assign atan_z = $signed({2'b00, atan_entry(5'(step_r))});

  assign cos_q = to_q16(x_r);
  assign sin_q = to_q16(y_r);

  always_comb begin
    state_nxt = state_r;
    dim_nxt   = dim_r;
    pos_nxt   = pos_r;
    err_nxt   = err_r;
    rp_nxt    = rp_r;
    p_nxt     = p_r;
    ang_nxt   = ang_r;
    prod_nxt  = prod_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    z_nxt     = z_r;
    step_nxt  = step_r;
    ov_nxt    = ov_r && out_stall;
    oc_nxt    = oc_r;
    oi_nxt    = oi_r;
    od_nxt    = od_r;
    ob_nxt    = ob_r;
    in_stall  = 1'b1;

    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          ang_nxt = in_angle;
          if (pos_r == 4'd0) begin
            err_nxt = in_radius[31];
            p_nxt   = in_radius[31] ? 32'd0 : in_radius;
          end else begin
            p_nxt = rp_r;
          end
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        prod_nxt  = prod_full;
        state_nxt = ST_PREP;
      end
      ST_PREP: begin
        // Angles beyond +-90 degrees are turned by pi before rotating.
        x_nxt     = fold ? -x_scaled : x_scaled;
        y_nxt     = '0;
        z_nxt     = $signed({{2{ang_r[31] ^ fold}}, ang_r[31] ^ fold, ang_r[30:0]});
        step_nxt  = '0;
        state_nxt = ST_ROT;
      end
      ST_ROT: begin
        if (!z_r[Z_W-1]) begin
          x_nxt = x_r - dx;
          y_nxt = y_r + dy;
          z_nxt = z_r - atan_z;
        end else begin
          x_nxt = x_r + dx;
          y_nxt = y_r - dy;
          z_nxt = z_r + atan_z;
        end
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(CORDIC_STEPS - 1)) begin
          state_nxt = ST_EMIT0;
        end
      end
      ST_EMIT0: begin
        if (out_free) begin
          ov_nxt = 1'b1;
          oc_nxt = err_r ? 32'd0 : cos_q;
          oi_nxt = last_angle ? 4'd0 : idx_full[3:0];
          od_nxt = 1'b0;
          ob_nxt = err_r;
          if (last_angle) begin
            state_nxt = ST_EMIT1;
          end else begin
            rp_nxt    = sin_q;
            pos_nxt   = pos_r + 4'd1;
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_EMIT1: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          oc_nxt    = err_r ? 32'd0 : sin_q;
          oi_nxt    = 4'd1;
          od_nxt    = 1'b1;
          ob_nxt    = err_r;
          rp_nxt    = 32'd0;
          pos_nxt   = 4'd0;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (cfg_wr_en) begin
      dim_nxt = cfg_wr_data;
      pos_nxt = 4'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      dim_r   <= 5'd3;
      pos_r   <= 4'd0;
      err_r   <= 1'b0;
      rp_r    <= 32'd0;
      step_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      dim_r   <= dim_nxt;
      pos_r   <= pos_nxt;
      err_r   <= err_nxt;
      rp_r    <= rp_nxt;
      step_r  <= step_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_r    <= p_nxt;
    ang_r  <= ang_nxt;
    prod_r <= prod_nxt;
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    z_r    <= z_nxt;
    oc_r   <= oc_nxt;
    oi_r   <= oi_nxt;
    od_r   <= od_nxt;
    ob_r   <= ob_nxt;
  end

  assign out_valid           = ov_r;
  assign out_component       = oc_r;
  assign out_component_index = oi_r;
  assign out_vector_done     = od_r;
  assign out_bad_radius      = ob_r;

endmodule

// ===== verif/tb_hyperspherical_to_cartesian.sv =====
`timescale 1ns / 1ps

module tb_hyperspherical_to_cartesian;
  import h2c_pkg::*;

  localparam int  HALF_PERIOD  = 6;
  localparam int  RESET_CYCLES = 12;
  localparam int  SETTLE       = 30;
  localparam int  HOLD_CYCLES  = 400;
  localparam int  QUIET_LIMIT  = 4000;
  localparam int  RANDOM_ITEMS = 1050;
  localparam longint GAIN_COMP = 64'sd1304065748;

  typedef struct {
    logic signed [31:0] value;
    logic [3:0]         index;
    logic               last;
    logic               bad;
  } component_t;

  class h2c_scoreboard;
    component_t  expected_q[$];
    longint      atan_lut[32];
    logic [4:0]  dim_reg;
    logic [31:0] product;
    int          position;
    logic        err;
    int          errors;
    int          results_seen;
    int          bad_vectors;

    function new();
      atan_lut = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                   10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
                   83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
                   81, 41, 20, 10, 5, 3, 1, 1, 0};
      dim_reg      = 5'd3;
      product      = '0;
      position     = 0;
      err          = 1'b0;
      errors       = 0;
      results_seen = 0;
      bad_vectors  = 0;
    endfunction

    function int effective_dim();
      int d;
      d = dim_reg;
      if (d < 2) d = 2;
      if (d > MAX_DIM) d = MAX_DIM;
      if (d > 16) d = 16;
      return d;
    endfunction

    function void write_dimension(logic [4:0] v);
      dim_reg  = v;
      position = 0;
    endfunction

    function logic [31:0] round_q16(longint v);
      longint r;
      r = (v + 64'sd32768) >>> 16;
      if (r > 64'sd2147483647) r = 64'sd2147483647;
      if (r < -64'sd2147483648) r = -64'sd2147483648;
      return r[31:0];
    endfunction

    // Rotation-mode CORDIC of (p * gain, 0); angles beyond +-90 degrees are
    // folded by a half turn first.
    function void rotate_product(input logic [31:0] p, input logic [31:0] a,
                                 output logic [31:0] c, output logic [31:0] s);
      longint x, y, z, dx, dy;
      logic [31:0] ang;
      x   = (longint'(signed'(p)) * GAIN_COMP) >>> 15;
      y   = 0;
      ang = a;
      if (ang[31] ^ ang[30]) begin
        x   = -x;
        ang = ang + 32'h8000_0000;
      end
      z = longint'(signed'(ang));
      for (int i = 0; i < CORDIC_STEPS && i < 32; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x = x - dx;
          y = y + dy;
          z = z - atan_lut[i];
        end else begin
          x = x + dx;
          y = y - dy;
          z = z + atan_lut[i];
        end
      end
      c = round_q16(x);
      s = round_q16(y);
    endfunction

    function void push_component(logic [31:0] v, int idx, logic last);
      component_t e;
      e.value = err ? 32'sd0 : signed'(v);
      e.index = idx[3:0];
      e.last  = last;
      e.bad   = err;
      expected_q = {expected_q, e};
    endfunction

    function void note_input(logic [31:0] radius, logic [31:0] angle);
      int eff;
      logic [31:0] c, s;
      eff = effective_dim();
      if (position == 0) begin
        err     = radius[31];
        product = err ? 32'd0 : radius;
        if (err) bad_vectors++;
      end
      rotate_product(product, angle, c, s);
      if (position + 1 >= eff - 1) begin
        push_component(c, 0, 1'b0);
        push_component(s, 1, 1'b1);
        position = 0;
        product  = '0;
      end else begin
        push_component(c, eff - 1 - position, 1'b0);
        product  = s;
        position = position + 1;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    task report(string msg);
      if (errors < 50) $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(logic signed [31:0] value, logic [3:0] index, logic last,
                      logic bad);
      component_t e;
      results_seen++;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result value=%0d index=%0d", value, index));
      end else begin
        e = expected_q.pop_front();
        if (value !== e.value)
          report($sformatf("component got %0d expected %0d (index %0d)",
                           value, e.value, e.index));
        if (index !== e.index)
          report($sformatf("component_index got %0d expected %0d", index, e.index));
        if (last !== e.last)
          report($sformatf("vector_done got %b expected %b", last, e.last));
        if (bad !== e.bad)
          report($sformatf("bad_radius got %b expected %b", bad, e.bad));
      end
    endtask
  endclass

  logic               clk;
  logic               rst_n;
  logic               cfg_wr_en;
  logic [4:0]         cfg_wr_data;
  logic               in_valid;
  logic               in_stall;
  logic signed [31:0] in_radius;
  logic signed [31:0] in_angle;
  logic               out_valid;
  logic               out_stall;
  logic signed [31:0] out_component;
  logic [3:0]         out_component_index;
  logic               out_vector_done;
  logic               out_bad_radius;

  h2c_scoreboard model = new();

  bit tx_idle_on;
  bit rx_idle_on;
  bit hold_req;
  int items_sent;
  int dim_writes;
  int holds_done;

  hyperspherical_to_cartesian dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_radius           (in_radius),
    .in_angle            (in_angle),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_component       (out_component),
    .out_component_index (out_component_index),
    .out_vector_done     (out_vector_done),
    .out_bad_radius      (out_bad_radius)
  );

  initial begin
    clk = 1'b0;
    forever #(HALF_PERIOD) clk = ~clk;
  end

  // Mostly no gap or a short one, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [31:0] pick_radius();
    case ($urandom_range(0, 9))
      0:       return 32'd0;
      1:       return 32'h8000_0000 | $urandom;
      2:       return 32'h7FFF_FFFF - $urandom_range(0, 1000);
      3, 4, 5: return $urandom_range(1, 32'h00FF_FFFF);
      default: return $urandom & 32'h7FFF_FFFF;
    endcase
  endfunction

  function automatic logic [31:0] pick_angle();
    if ($urandom_range(0, 7) == 0) begin
      case ($urandom_range(0, 7))
        0:       return 32'h0000_0000;
        1:       return 32'h4000_0000;
        2:       return 32'h8000_0000;
        3:       return 32'hC000_0000;
        4:       return 32'h7FFF_FFFF;
        5:       return 32'h3FFF_FFFF;
        6:       return 32'hBFFF_FFFF;
        default: return 32'h4000_0001;
      endcase
    end
    return $urandom;
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer,
  // leaving valid high so back-to-back items need no extra toggling.
  task automatic send_angle(input logic [31:0] radius, input logic [31:0] angle);
    int gap;
    gap = tx_idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_radius <= radius;
    in_angle  <= angle;
    do @(posedge clk); while (in_stall);
    model.note_input(radius, angle);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_vector(input int eff);
    send_angle(pick_radius(), pick_angle());
    repeat (eff - 2) send_angle($urandom, pick_angle());
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (model.pending() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_dimension(input logic [4:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    model.write_dimension(v);
    dim_writes++;
  endtask

  // Receiver side: random stall runs, plus one long hold-off on request.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
        holds_done++;
      end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat (pick_gap() + 1) @(negedge clk);
      end
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      model.check_result(out_component, out_component_index, out_vector_done,
                         out_bad_radius);
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("Timeout: no transfer in %0d cycles", QUIET_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    logic [4:0] phase_dims [8];
    logic [4:0] d;
    int phase, budget, count, eff;

    phase_dims  = '{5'd16, 5'd17, 5'd31, 5'd1, 5'd2, 5'd5, 5'd9, 5'd3};
    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    in_valid    = 1'b0;
    in_radius   = '0;
    in_angle    = '0;
    tx_idle_on  = 1'b0;
    rx_idle_on  = 1'b0;
    hold_req    = 1'b0;
    items_sent  = 0;
    dim_writes  = 0;
    holds_done  = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part at the reset dimension of three: unit, full-scale, zero
    // and negative radii, quadrant edges, and a radius on a later angle.
    send_angle(32'h0001_0000, 32'h0000_0000);
    send_angle(32'h0000_0000, 32'h4000_0000);
    send_angle(32'h7FFF_FFFF, 32'h8000_0000);
    send_angle(32'hDEAD_BEEF, 32'h7FFF_FFFF);
    send_angle(32'h0000_0000, 32'h2000_0000);
    send_angle(32'h0000_0000, 32'hC000_0000);
    send_angle(32'h8000_0000, 32'h1234_5678);
    send_angle(32'h7FFF_FFFF, 32'hBFFF_FFFF);
    send_angle(32'h7FFF_FFFF, 32'h4000_0000);
    send_angle(32'h0000_0000, 32'h0000_0000);
    wait_drained();

    // Dimension two: the single angle is both first and last.
    write_dimension(5'd2);
    send_angle(32'h7FFF_FFFF, 32'h0000_0000);
    send_angle(32'hFFFF_FFFF, 32'h6000_0000);
    send_angle(32'h0003_2000, 32'hA000_0000);
    wait_drained();

    // A partial vector, abandoned by the next dimension write.
    write_dimension(5'd4);
    send_angle(32'h0010_0000, 32'h1000_0000);
    wait_drained();
    write_dimension(5'd0);
    send_angle(32'h0001_8000, 32'hE000_0000);
    send_angle(32'h0000_0001, 32'h8000_0001);
    wait_drained();

    phase = 0;
    while (items_sent < RANDOM_ITEMS) begin
      d = (phase < 8) ? phase_dims[phase] : 5'($urandom_range(0, 31));
      write_dimension(d);
      eff = model.effective_dim();
      tx_idle_on = (phase > 1) && ($urandom_range(0, 3) != 0);
      rx_idle_on = (phase > 1) && ($urandom_range(0, 3) != 0);
      // The long receiver hold-off lets the block back up onto its input.
      if (phase == 1) hold_req = 1'b1;
      budget = $urandom_range(40, 120);
      count  = 0;
      while (count < budget && items_sent < RANDOM_ITEMS) begin
        send_vector(eff);
        count += eff - 1;
      end
      if (eff > 2 && $urandom_range(0, 2) == 0)
        repeat ($urandom_range(1, eff - 2)) send_angle(pick_radius(), pick_angle());
      wait_drained();
      phase++;
    end

    if (model.pending() != 0)
      model.report($sformatf("%0d expected results never arrived", model.pending()));
    $display("Summary: %0d angle transfers, %0d component results, %0d dimension writes.",
             items_sent, model.results_seen, dim_writes);
    $display("Summary: %0d negative-radius vectors, %0d long receiver hold-offs.",
             model.bad_vectors, holds_done);
    if (model.errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
